@@ src/drlt_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths, constants and helper functions for the local time block
// no dependencies
package drlt_pkg;

  localparam int T_W    = 34;
  localparam int INST_W = 35;
  localparam int DAY_W  = 15;
  localparam int YS_W   = 16;
  localparam int HMS_W  = 17;
  localparam int BSEC_W = 18;

  localparam int DAYDIV_LAT = 3;
  localparam int YEAR_LAT   = 3;
  localparam int RULE_LAT   = 3;
  localparam int PIPE_DEPTH = DAYDIV_LAT + YEAR_LAT + RULE_LAT;

  localparam logic signed [T_W:0] YEAR_1969_SECS = 35'sd31536000;
  localparam logic [25:0] DIV675_MUL = 26'd50903316;
  localparam logic [9:0] DAY_ODD = 10'd675;
  localparam logic [15:0] DIV1461_MUL = 16'd45933;
  localparam logic [10:0] CYCLE_DAYS = 11'd1461;
  localparam logic [8:0] YEAR_DAYS = 9'd365;
  localparam logic signed [INST_W-1:0] SECS_DAY = 35'sd86400;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BIAS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_BIAS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_BIAS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_RULE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_RULE  = 3'd4;

  localparam logic signed [11:0] DST_BIAS_RST = -12'sd60;
  localparam logic [29:0] STD_RULE_RST = 30'd336207872;
  localparam logic [29:0] DST_RULE_RST = 30'd134356992;

  typedef struct packed {
    logic       absolute;
    logic [3:0] month;
    logic [2:0] wday;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] sec;
  } rule_t;

  typedef struct packed {
    logic [DAY_W-1:0] days;
    logic             oor;
  } day_t;

  typedef struct packed {
    logic [YS_W-1:0]        ys;
    logic signed [YS_W-1:0] to_year;
    logic                   leap;
    logic                   oor;
  } year_t;

  function automatic logic signed [BSEC_W-1:0] min_to_sec(input logic signed [11:0] m);
    return BSEC_W'(m) * 18'sd60;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = leap ? 9'd60  : 9'd59;
      4'd3:    d = leap ? 9'd91  : 9'd90;
      4'd4:    d = leap ? 9'd121 : 9'd120;
      4'd5:    d = leap ? 9'd152 : 9'd151;
      4'd6:    d = leap ? 9'd182 : 9'd181;
      4'd7:    d = leap ? 9'd213 : 9'd212;
      4'd8:    d = leap ? 9'd244 : 9'd243;
      4'd9:    d = leap ? 9'd274 : 9'd273;
      4'd10:   d = leap ? 9'd305 : 9'd304;
      4'd11:   d = leap ? 9'd335 : 9'd334;
      4'd12:   d = leap ? 9'd366 : 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // 8 = 1 mod 7, so octal digits fold
  function automatic logic [2:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

@@ src/drlt_day_div.sv @@
`timescale 1ns / 1ps
// three stage floor division of corrected seconds into days since 1969-01-01
// depends on drlt_pkg
module drlt_day_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic signed [drlt_pkg::T_W-1:0] in_t,
  output logic                        out_valid,
  output drlt_pkg::day_t              out_day
);
  import drlt_pkg::*;

  logic signed [T_W:0] tt;
  logic [50:0] prod;
  logic [15:0] q0;
  logic [25:0] qm;
  logic [25:0] rem;
  logic        ge;
  logic [15:0] dq;
  day_t        day_nxt;

  logic        va_r, vb_r, out_valid_r;
  logic        oor_a_r, oor_b_r;
  logic [24:0] x_a_r, x_b_r;
  logic [15:0] q0_b_r;
  day_t        day_r;

  assign tt   = (T_W + 1)'(in_t) + YEAR_1969_SECS;
  assign prod = 51'(x_a_r) * 51'(DIV675_MUL);
  assign q0   = prod[50:35];
  assign qm   = 26'(q0_b_r) * 26'(DAY_ODD);
  assign rem  = 26'(x_b_r) - qm;
  assign ge   = rem >= 26'(DAY_ODD);
  assign dq   = q0_b_r + 16'(ge);

  always_comb begin
    day_nxt.days = dq[DAY_W-1:0];
    day_nxt.oor  = oor_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    oor_a_r <= tt[T_W];
    x_a_r   <= tt[31:7];
    oor_b_r <= oor_a_r;
    x_b_r   <= x_a_r;
    q0_b_r  <= q0;
    day_r   <= day_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_day   = day_r;

endmodule

@@ src/drlt_year.sv @@
`timescale 1ns / 1ps
// three stage split of a day count into four year cycles and year in cycle
// depends on drlt_pkg
module drlt_year (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  drlt_pkg::day_t  in_day,
  output logic            out_valid,
  output drlt_pkg::year_t out_year
);
  import drlt_pkg::*;

  logic [30:0] prod;
  logic [4:0]  q0;
  logic [15:0] qm;
  logic [15:0] rem;
  logic        ge;
  logic [15:0] rem_adj;
  logic [1:0]  yic;
  logic [15:0] ys;
  year_t       year_nxt;

  logic             va_r, vb_r, out_valid_r;
  logic             oor_a_r, oor_b_r;
  logic [4:0]       q0_a_r, q_b_r;
  logic [DAY_W-1:0] d_a_r;
  logic [10:0]      r_b_r;
  year_t            year_r;

  assign prod    = 31'(in_day.days) * 31'(DIV1461_MUL);
  assign q0      = prod[30:26];
  assign qm      = 16'(q0_a_r) * 16'(CYCLE_DAYS);
  assign rem     = 16'(d_a_r) - qm;
  assign ge      = rem >= 16'(CYCLE_DAYS);
  assign rem_adj = ge ? rem - 16'(CYCLE_DAYS) : rem;

  always_comb begin
    if (r_b_r >= 11'd1095) begin
      yic = 2'd3;
    end else if (r_b_r >= 11'd730) begin
      yic = 2'd2;
    end else if (r_b_r >= 11'(YEAR_DAYS)) begin
      yic = 2'd1;
    end else begin
      yic = 2'd0;
    end
    ys = 16'(q_b_r) * 16'(CYCLE_DAYS) + 16'(yic) * 16'(YEAR_DAYS);
    year_nxt.ys      = ys;
    year_nxt.to_year = $signed(ys) - $signed(16'(YEAR_DAYS));
    year_nxt.leap    = yic == 2'd3;
    year_nxt.oor     = oor_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    q0_a_r  <= q0;
    d_a_r   <= in_day.days;
    oor_a_r <= in_day.oor;
    q_b_r   <= q0_a_r + 5'(ge);
    r_b_r   <= rem_adj[10:0];
    oor_b_r <= oor_a_r;
    year_r  <= year_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_year  = year_r;

endmodule

@@ src/drlt_rule_inst.sv @@
`timescale 1ns / 1ps
// three stage transition instant of one rule for a given year
// depends on drlt_pkg
module drlt_rule_inst (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  drlt_pkg::year_t                   in_year,
  input  drlt_pkg::rule_t                   rule,
  input  logic signed [drlt_pkg::BSEC_W-1:0] adj,
  output logic                              out_valid,
  output logic signed [drlt_pkg::INST_W-1:0] out_instant
);
  import drlt_pkg::*;

  logic [8:0]  base;
  logic [8:0]  mend;
  logic [15:0] dsum;

  logic signed [4:0]  diff;
  logic signed [6:0]  k;
  logic signed [10:0] yd_nxt;
  logic [HMS_W-1:0]   hms;
  logic signed [INST_W-1:0] ty_nxt;

  logic                     va_r, vb_r, out_valid_r;
  logic [2:0]               mdow_a_r;
  logic [8:0]               base_a_r, mend_a_r;
  logic signed [YS_W-1:0]   to_year_a_r;
  logic signed [10:0]       yd_b_r;
  logic signed [INST_W-1:0] ty_b_r;
  logic signed [INST_W-1:0] inst_r;

  assign base = cum_days(rule.month - 4'd1, in_year.leap);
  assign mend = cum_days(rule.month, in_year.leap);
  assign dsum = in_year.ys + 16'(base) + 16'd3;

  always_comb begin
    diff = $signed({2'b00, rule.wday}) - $signed({2'b00, mdow_a_r});
    if (mdow_a_r < rule.wday) begin
      k = $signed({2'b00, rule.day}) - 7'sd1;
    end else begin
      k = $signed({2'b00, rule.day});
    end
    if (rule.absolute) begin
      yd_nxt = $signed({2'b00, base_a_r}) + $signed({6'b0, rule.day}) - 11'sd1;
    end else begin
      yd_nxt = $signed({2'b00, base_a_r}) + 11'(diff) + 11'(k) * 11'sd7;
      if (rule.day == 5'd5 && yd_nxt >= $signed({2'b00, mend_a_r})) begin
        yd_nxt = yd_nxt - 11'sd7;
      end
    end
  end

  assign hms = HMS_W'(rule.hour) * 17'd3600 + HMS_W'(rule.minute) * 17'd60
             + HMS_W'(rule.sec);
  assign ty_nxt = INST_W'(to_year_a_r) * SECS_DAY + $signed(INST_W'(hms)) + INST_W'(adj);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    mdow_a_r    <= mod7(dsum);
    base_a_r    <= base;
    mend_a_r    <= mend;
    to_year_a_r <= in_year.to_year;
    yd_b_r      <= yd_nxt;
    ty_b_r      <= ty_nxt;
    inst_r      <= ty_b_r + INST_W'(yd_b_r) * SECS_DAY;
  end

  assign out_valid   = out_valid_r;
  assign out_instant = inst_r;

endmodule

@@ src/dst_rule_local_time.sv @@
`timescale 1ns / 1ps
// top level: configuration registers, zone bias stage, daylight decision and output register
// depends on drlt_pkg, drlt_day_div, drlt_year, drlt_rule_inst
//
// Converts a UTC second count to local seconds under a two-rule daylight scheme.
// One conversion is taken every clock: busy stays low and start may be held high
// continuously. Each accepted item gives exactly one result, strobed on out_valid
// for a single cycle; the pipeline is eleven register stages (zone bias, three
// for the day division, three for the year split, three for the rule instants,
// one for the compare and final bias). The result cannot be held off, so the
// receiver must take it in that cycle. Configuration writes are always ready and
// should only be issued while no conversion is in flight.
module dst_rule_local_time (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                in_utc_seconds,
  output logic                              out_valid,
  output logic signed [31:0]                out_local_seconds,
  output logic                              out_is_dst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [drlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata
);
  import drlt_pkg::*;

  logic signed [11:0] zone_bias_r, std_bias_r, dst_bias_r;
  rule_t              std_rule_r, dst_rule_r;

  logic                  v_r;
  logic signed [T_W-1:0] t_r;
  logic signed [T_W-1:0] t_pipe_r [PIPE_DEPTH];
  logic                  oor_pipe_r [RULE_LAT];

  logic                  day_v;
  day_t                  day_s;
  logic                  year_v;
  year_t                 year_s;
  logic                  start_v, end_v;
  logic signed [INST_W-1:0] start_i, end_i;

  logic signed [T_W-1:0]    t_nxt;
  logic signed [T_W-1:0]    t_f;
  logic signed [INST_W-1:0] tx;
  logic                     rules_on;
  logic                     in_win;
  logic                     dst_nxt;
  logic signed [T_W-1:0]    loc_d, loc_s;

  logic               out_valid_r;
  logic signed [31:0] out_local_r;
  logic               out_dst_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_bias_r <= 12'sd0;
      std_bias_r  <= 12'sd0;
      dst_bias_r  <= DST_BIAS_RST;
      std_rule_r  <= rule_t'(STD_RULE_RST);
      dst_rule_r  <= rule_t'(DST_RULE_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ZONE_BIAS: zone_bias_r <= $signed(cfg_wdata[11:0]);
        CFG_STD_BIAS:  std_bias_r  <= $signed(cfg_wdata[11:0]);
        CFG_DST_BIAS:  dst_bias_r  <= $signed(cfg_wdata[11:0]);
        CFG_STD_RULE:  std_rule_r  <= rule_t'(cfg_wdata[29:0]);
        CFG_DST_RULE:  dst_rule_r  <= rule_t'(cfg_wdata[29:0]);
        default: ;
      endcase
    end
  end

  assign t_nxt = T_W'(in_utc_seconds) - T_W'(min_to_sec(zone_bias_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= start && !busy;
      out_valid_r <= start_v;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    t_pipe_r[0] <= t_r;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      t_pipe_r[i] <= t_pipe_r[i-1];
    end
    oor_pipe_r[0] <= year_s.oor;
    for (int i = 1; i < RULE_LAT; i++) begin
      oor_pipe_r[i] <= oor_pipe_r[i-1];
    end
  end

  drlt_day_div u_day_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r),
    .in_t      (t_r),
    .out_valid (day_v),
    .out_day   (day_s)
  );

  drlt_year u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (day_v),
    .in_day    (day_s),
    .out_valid (year_v),
    .out_year  (year_s)
  );

  drlt_rule_inst u_start (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (year_v),
    .in_year     (year_s),
    .rule        (dst_rule_r),
    .adj         ('0),
    .out_valid   (start_v),
    .out_instant (start_i)
  );

  // end instant is shifted by the daylight bias
  drlt_rule_inst u_end (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (year_v),
    .in_year     (year_s),
    .rule        (std_rule_r),
    .adj         (min_to_sec(dst_bias_r)),
    .out_valid   (end_v),
    .out_instant (end_i)
  );

  assign t_f = t_pipe_r[PIPE_DEPTH-1];
  assign tx  = INST_W'(t_f);

  assign rules_on = (std_rule_r.month != 4'd0) && (dst_rule_r.month != 4'd0)
                 && (std_rule_r.month <= 4'd12) && (dst_rule_r.month <= 4'd12)
                 && !oor_pipe_r[RULE_LAT-1];

  always_comb begin
    if (start_i < end_i) begin
      in_win = (tx >= start_i) && (tx < end_i);
    end else if (start_i > end_i) begin
      in_win = (tx < end_i) || (tx >= start_i);
    end else begin
      in_win = 1'b0;
    end
    dst_nxt = rules_on && in_win && end_v;
  end

  assign loc_d = t_f - T_W'(min_to_sec(dst_bias_r));
  assign loc_s = t_f - T_W'(min_to_sec(std_bias_r));

  always_ff @(posedge clk) begin
    out_dst_r   <= dst_nxt;
    out_local_r <= dst_nxt ? loc_d[31:0] : loc_s[31:0];
  end

  assign out_valid         = out_valid_r;
  assign out_local_seconds = out_local_r;
  assign out_is_dst        = out_dst_r;

endmodule
